[src/bstf_pkg.sv]
// Types and constants shared by the banked scroll tilemap fetch unit.
package bstf_pkg;

    localparam int RAM_DEPTH = 16384;
    localparam int RAM_AW    = 14;

    // request modes
    typedef enum logic [1:0] {
        MODE_WRITE  = 2'd0,
        MODE_READ   = 2'd1,
        MODE_PAGE   = 2'd2,
        MODE_FETCH  = 2'd3
    } mode_t;

    // configuration register indexes
    localparam logic [1:0] REG_LAYOUT   = 2'd0;
    localparam logic [1:0] REG_SCROLL_X = 2'd1;
    localparam logic [1:0] REG_SCROLL_Y = 2'd2;

    typedef struct packed {
        mode_t       mode;
        logic [11:0] cpu_offset;
        logic [7:0]  cpu_data;
        logic [4:0]  screen_col;
        logic [4:0]  screen_row;
    } in_t;

    typedef struct packed {
        logic [7:0]  read_byte;
        logic [10:0] tile_code;
        logic [3:0]  tile_colour;
        logic        flip_x;
        logic        was_dirty;
        logic [6:0]  map_col;
        logic [6:0]  map_row;
    } out_t;

endpackage

[src/bstf_ram.sv]
// Generic single-port RAM with registered, read-before-write data output.
module bstf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read the old contents, then write
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata <= mem[addr];
            if (we)
            begin
                mem[addr] <= wdata;
            end
        end
    end

endmodule

[src/banked_scroll_tilemap_fetch_unit.sv]
// Banked scroll tilemap fetch unit: top level with sequencer, registers and RAMs.
//
// After reset the unit runs a clearing pass that zeroes the scroll RAM and
// marks every byte dirty; in_ready stays low until it ends, while configuration
// writes are taken throughout. A CPU write, read or page select then goes from
// ST_IDLE to ST_FINISH, and a tile fetch passes through ST_FETCH2 between them,
// because both tile bytes go through the one port of the byte-wide scroll RAM,
// each read clearing its dirty mark in the same access. A new request is taken
// once the result of the previous one is in the output register; a result
// waiting there holds the sequencer until it is taken.
module banked_scroll_tilemap_fetch_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  bstf_pkg::in_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output bstf_pkg::out_t out_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_FETCH2 = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t                         state_reg, state_next;
    logic [bstf_pkg::RAM_AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [1:0]                     page_reg, page_next;
    logic                           layout_reg;
    logic [15:0]                    scroll_x_reg, scroll_y_reg;
    bstf_pkg::mode_t                mode_reg, mode_next;
    logic [bstf_pkg::RAM_AW-1:0]    offs_reg, offs_next;
    logic [6:0]                     x_reg, x_next, y_reg, y_next;
    logic [7:0]                     code_reg, code_next;
    logic                           d0_reg, d0_next;
    logic                           out_valid_reg, out_valid_next;
    bstf_pkg::out_t                 out_data_reg, out_data_next;

    logic                           accept;
    logic                           cfg_write;
    logic [6:0]                     sum_x, sum_y, fx, fy;
    logic [bstf_pkg::RAM_AW-1:0]    fetch_offs, cpu_addr;
    logic                           ram_en, ram_we, dty_we;
    logic [bstf_pkg::RAM_AW-1:0]    ram_addr;
    logic [7:0]                     ram_wdata, ram_rdata;
    logic                           dty_wdata, dty_rdata;
    bstf_pkg::out_t                 result;
    logic                           out_free;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_reg   <= 1'b0;
            scroll_x_reg <= 16'd0;
            scroll_y_reg <= 16'd0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                bstf_pkg::REG_LAYOUT:   layout_reg   <= pwdata[0];
                bstf_pkg::REG_SCROLL_X: scroll_x_reg <= pwdata[15:0];
                bstf_pkg::REG_SCROLL_Y: scroll_y_reg <= pwdata[15:0];
                default:                ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (paddr[3:2])
            bstf_pkg::REG_LAYOUT:   prdata = {31'd0, layout_reg};
            bstf_pkg::REG_SCROLL_X: prdata = {16'd0, scroll_x_reg};
            bstf_pkg::REG_SCROLL_Y: prdata = {16'd0, scroll_y_reg};
            default:                prdata = 32'd0;
        endcase
    end

    // wrap the scrolled tile position and form the tile offset
    assign sum_x    = scroll_x_reg[10:4] + {2'b00, in_data.screen_col};
    assign sum_y    = scroll_y_reg[10:4] + {2'b00, in_data.screen_row};
    assign cpu_addr = {page_reg, in_data.cpu_offset};

    always_comb
    begin
        if (layout_reg)
        begin
            fx         = sum_x;
            fy         = {1'b0, sum_y[5:0]};
            fetch_offs = {fy[5:4], fx[6:4], fy[3:0], fx[3:0], 1'b0};
        end
        else
        begin
            fx         = {1'b0, sum_x[5:0]};
            fy         = sum_y;
            fetch_offs = {fy[6:4], fx[5:4], fy[3:0], fx[3:0], 1'b0};
        end
    end

    // build the result from the held request and the RAM output
    always_comb
    begin
        result = '0;
        case (mode_reg)
            bstf_pkg::MODE_READ:
            begin
                result.read_byte = ram_rdata;
            end
            bstf_pkg::MODE_FETCH:
            begin
                result.tile_code   = {ram_rdata[2:0], code_reg};
                result.tile_colour = ram_rdata[6:3];
                result.flip_x      = ram_rdata[7];
                result.was_dirty   = d0_reg || dty_rdata;
                result.map_col     = x_reg;
                result.map_row     = y_reg;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    // sequencer and RAM port control
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        page_next      = page_reg;
        mode_next      = mode_reg;
        offs_next      = offs_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        code_next      = code_reg;
        d0_next        = d0_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        ram_en         = 1'b0;
        ram_we         = 1'b0;
        dty_we         = 1'b0;
        ram_addr       = cpu_addr;
        ram_wdata      = in_data.cpu_data;
        dty_wdata      = 1'b1;

        case (state_reg)
            ST_CLEAR:
            begin
                // sweep the RAM: zero bytes, mark dirty
                ram_en       = 1'b1;
                ram_we       = 1'b1;
                dty_we       = 1'b1;
                ram_addr     = clr_cnt_reg;
                ram_wdata    = 8'd0;
                dty_wdata    = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next  = in_data.mode;
                    state_next = ST_FINISH;
                    case (in_data.mode)
                        bstf_pkg::MODE_WRITE:
                        begin
                            ram_en = 1'b1;
                            ram_we = 1'b1;
                            dty_we = 1'b1;
                        end
                        bstf_pkg::MODE_READ:
                        begin
                            ram_en = 1'b1;
                        end
                        bstf_pkg::MODE_PAGE:
                        begin
                            page_next = in_data.cpu_data[1:0];
                        end
                        default:
                        begin
                            // code byte: read and clear its mark
                            ram_en     = 1'b1;
                            dty_we     = 1'b1;
                            dty_wdata  = 1'b0;
                            ram_addr   = fetch_offs;
                            offs_next  = fetch_offs;
                            x_next     = fx;
                            y_next     = fy;
                            state_next = ST_FETCH2;
                        end
                    endcase
                end
            end
            ST_FETCH2:
            begin
                // attribute byte: read and clear its mark, hold the code byte
                ram_en     = 1'b1;
                dty_we     = 1'b1;
                dty_wdata  = 1'b0;
                ram_addr   = {offs_reg[bstf_pkg::RAM_AW-1:1], 1'b1};
                code_next  = ram_rdata;
                d0_next    = dty_rdata;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hand over the result once the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = result;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            page_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
            mode_reg      <= bstf_pkg::MODE_WRITE;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            page_reg      <= page_next;
            out_valid_reg <= out_valid_next;
            mode_reg      <= mode_next;
        end
    end

    // request payload
    always_ff @(posedge clk)
    begin
        offs_reg     <= offs_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        code_reg     <= code_next;
        d0_reg       <= d0_next;
        out_data_reg <= out_data_next;
    end

    bstf_ram #(
        .WIDTH (8),
        .DEPTH (bstf_pkg::RAM_DEPTH)
    ) u_tile_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    bstf_ram #(
        .WIDTH (1),
        .DEPTH (bstf_pkg::RAM_DEPTH)
    ) u_dirty_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (dty_we),
        .addr  (ram_addr),
        .wdata (dty_wdata),
        .rdata (dty_rdata)
    );

endmodule

[sim/testbench.sv]
// Self-checking testbench for the banked scroll tilemap fetch unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // receiver stall styles
    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_TOGGLE
    } rx_style_t;

    localparam int LONG_HOLD_CYCLES = 250;
    localparam int PHASE_REQS       = 90;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_ready;
    bstf_pkg::in_t  in_data = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    bstf_pkg::out_t out_data;
    logic           psel = 1'b0;
    logic           penable = 1'b0;
    logic           pwrite = 1'b0;
    logic [3:0]     paddr = '0;
    logic [31:0]    pwdata = '0;
    logic [31:0]    prdata;
    logic           pready;

    // shadow copy of the unit's state and registers
    logic [7:0]  ram_shadow [bstf_pkg::RAM_DEPTH];
    logic        dirty_shadow [bstf_pkg::RAM_DEPTH];
    logic [1:0]  page_shadow;
    logic        layout_shadow;
    logic [15:0] scroll_x_shadow;
    logic [15:0] scroll_y_shadow;

    bstf_pkg::in_t  pending_reqs [$];
    bstf_pkg::out_t expected_results [$];

    int          error_count = 0;
    int          results_seen = 0;
    int          reg_writes = 0;
    int          settings_run = 0;
    int          mode_hits [4] = '{0, 0, 0, 0};
    int          burst_left = 0;
    int          gap_left = 0;
    int          hold_left = 0;
    int          holds_done = 0;
    int          pattern_left = 0;
    rx_style_t   rx_style = RX_FREE;

    banked_scroll_tilemap_fetch_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Wrap the scrolled screen tile into the map and give its even RAM offset
    function automatic logic [13:0] tile_offset(input logic [4:0] col, input logic [4:0] row,
                                                output logic [6:0] map_c,
                                                output logic [6:0] map_r);
        int unsigned tx;
        int unsigned ty;
        int unsigned x;
        int unsigned y;
        int unsigned base;
        int unsigned offs;
        tx = scroll_x_shadow >> 4;
        ty = scroll_y_shadow >> 4;
        if (layout_shadow)
        begin
            y = (ty + row) & 63;
            x = (tx + col) & 127;
            base = ((y & 'hf0) << 8) + 32 * (y & 'h0f);
        end
        else
        begin
            y = (ty + row) & 127;
            x = (tx + col) & 63;
            base = ((y & 'hf0) << 7) + 32 * (y & 'h0f);
        end
        offs = (base + ((x & 'hf0) << 5) + 2 * (x & 'h0f)) & (bstf_pkg::RAM_DEPTH - 1) & ~1;
        map_c = 7'(x);
        map_r = 7'(y);
        return 14'(offs);
    endfunction

    // Apply one request to the shadow state and return the result it gives
    function automatic bstf_pkg::out_t tilemap_step(input bstf_pkg::in_t req);
        bstf_pkg::out_t res;
        logic [13:0]    addr;
        logic [13:0]    offs;
        logic [13:0]    attr_addr;
        logic [7:0]     code_b;
        logic [7:0]     attr;
        logic [6:0]     map_c;
        logic [6:0]     map_r;
        res = '0;
        addr = {page_shadow, req.cpu_offset};
        mode_hits[req.mode]++;
        case (req.mode)
            bstf_pkg::MODE_WRITE:
            begin
                ram_shadow[addr] = req.cpu_data;
                dirty_shadow[addr] = 1'b1;
            end
            bstf_pkg::MODE_READ:
            begin
                res.read_byte = ram_shadow[addr];
            end
            bstf_pkg::MODE_PAGE:
            begin
                page_shadow = req.cpu_data[1:0];
            end
            default:
            begin
                offs = tile_offset(req.screen_col, req.screen_row, map_c, map_r);
                attr_addr = {offs[13:1], 1'b1};
                code_b = ram_shadow[offs];
                attr = ram_shadow[attr_addr];
                res.tile_code = {attr[2:0], code_b};
                res.tile_colour = attr[6:3];
                res.flip_x = attr[7];
                res.was_dirty = dirty_shadow[offs] | dirty_shadow[attr_addr];
                res.map_col = map_c;
                res.map_row = map_r;
                dirty_shadow[offs] = 1'b0;
                dirty_shadow[attr_addr] = 1'b0;
            end
        endcase
        return res;
    endfunction

    function automatic bstf_pkg::in_t make_req(input bstf_pkg::mode_t m, input logic [11:0] off,
                                               input logic [7:0] d,
                                               input logic [4:0] col, input logic [4:0] row);
        bstf_pkg::in_t r;
        r.mode = m;
        r.cpu_offset = off;
        r.cpu_data = d;
        r.screen_col = col;
        r.screen_row = row;
        return r;
    endfunction

    task automatic queue_req(input bstf_pkg::in_t r);
        pending_reqs.push_back(r);
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
        end
    endtask

    // Register write over the APB port, then mirror it in the shadow copy
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            bstf_pkg::REG_LAYOUT:   layout_shadow = val[0];
            bstf_pkg::REG_SCROLL_X: scroll_x_shadow = val[15:0];
            bstf_pkg::REG_SCROLL_Y: scroll_y_shadow = val[15:0];
            default:                ;
        endcase
        reg_writes++;
    endtask

    task automatic apply_setting(input logic lay, input logic [15:0] sx, input logic [15:0] sy);
        write_reg(bstf_pkg::REG_LAYOUT, ($urandom() & ~32'd1) | 32'(lay));
        write_reg(bstf_pkg::REG_SCROLL_X, {16'($urandom()), sx});
        write_reg(bstf_pkg::REG_SCROLL_Y, {16'($urandom()), sy});
        settings_run++;
    endtask

    // Hold until every request has gone in and every result has come out
    task automatic wait_drained(input int settle);
        while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Select the tile's page, write one or both of its bytes, then fetch it
    task automatic queue_tile_sequence(inout int count);
        logic [4:0]  col;
        logic [4:0]  row;
        logic [13:0] offs;
        logic [6:0]  map_c;
        logic [6:0]  map_r;
        int          shape;
        col = 5'($urandom_range(0, 31));
        row = 5'($urandom_range(0, 31));
        offs = tile_offset(col, row, map_c, map_r);
        shape = $urandom_range(0, 7);
        queue_req(make_req(bstf_pkg::MODE_PAGE, 12'($urandom()),
                           {6'($urandom()), offs[13:12]},
                           5'($urandom()), 5'($urandom())));
        count++;
        if (shape != 1)
        begin
            queue_req(make_req(bstf_pkg::MODE_WRITE, offs[11:0], 8'($urandom()),
                               5'($urandom()), 5'($urandom())));
            count++;
        end
        if (shape != 2)
        begin
            queue_req(make_req(bstf_pkg::MODE_WRITE, {offs[11:1], 1'b1}, 8'($urandom()),
                               5'($urandom()), 5'($urandom())));
            count++;
        end
        if (shape == 3)
        begin
            queue_req(make_req(bstf_pkg::MODE_READ, offs[11:0], 8'($urandom()),
                               5'($urandom()), 5'($urandom())));
            count++;
        end
        queue_req(make_req(bstf_pkg::MODE_FETCH, 12'($urandom()), 8'($urandom()), col, row));
        count++;
        if (shape >= 6)
        begin
            queue_req(make_req(bstf_pkg::MODE_FETCH, 12'($urandom()), 8'($urandom()),
                               col, row));
            count++;
        end
    endtask

    // Mostly well-formed tile sequences, the rest arbitrary requests
    task automatic fill_phase(input int target);
        int count;
        count = 0;
        @(negedge clk);
        while (count < target)
        begin
            if ($urandom_range(0, 9) < 6)
                queue_tile_sequence(count);
            else
            begin
                queue_req(make_req(bstf_pkg::mode_t'($urandom_range(0, 3)), 12'($urandom()),
                                   8'($urandom()), 5'($urandom()), 5'($urandom())));
                count++;
            end
        end
    endtask

    // Request driver: bursts of random length with random gaps
    always @(posedge clk)
    begin : drive_requests
        logic          nv;
        bstf_pkg::in_t nxt;
        if (rst_n)
        begin
            nv = in_valid;
            nxt = in_data;
            if (in_valid && in_ready)
            begin
                expected_results.push_back(tilemap_step(in_data));
                nv = 1'b0;
            end
            if (!nv)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_reqs.size() > 0)
                begin
                    nxt = pending_reqs.pop_front();
                    nv = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
            in_valid <= nv;
            in_data <= nxt;
        end
    end

    // Result monitor and receiver stall pattern
    always @(posedge clk)
    begin : collect_results
        bstf_pkg::out_t exp_res;
        logic           nr;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result 0x%0h arrived with none expected", $time, out_data);
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    check_field("read_byte", exp_res.read_byte, out_data.read_byte);
                    check_field("tile_code", exp_res.tile_code, out_data.tile_code);
                    check_field("tile_colour", exp_res.tile_colour, out_data.tile_colour);
                    check_field("flip_x", exp_res.flip_x, out_data.flip_x);
                    check_field("was_dirty", exp_res.was_dirty, out_data.was_dirty);
                    check_field("map_col", exp_res.map_col, out_data.map_col);
                    check_field("map_row", exp_res.map_row, out_data.map_row);
                end
                results_seen++;
            end
            // long hold-off while the sender still has plenty queued
            if (hold_left > 0)
            begin
                hold_left--;
                nr = 1'b0;
            end
            else if (holds_done < 2 && results_seen >= 150 + 250 * holds_done
                     && pending_reqs.size() > 16)
            begin
                hold_left = LONG_HOLD_CYCLES;
                holds_done++;
                nr = 1'b0;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    rx_style = rx_style_t'($urandom_range(0, 3));
                    pattern_left = $urandom_range(20, 120);
                end
                pattern_left--;
                case (rx_style)
                    RX_FREE:   nr = 1'b1;
                    RX_COIN:   nr = 1'($urandom_range(0, 1));
                    RX_SPARSE: nr = ($urandom_range(0, 3) == 0);
                    default:   nr = ~out_ready;
                endcase
            end
            out_ready <= nr;
        end
    end

    // Stimulus: directed requests, then random phases under several settings
    initial
    begin
        for (int i = 0; i < bstf_pkg::RAM_DEPTH; i++)
        begin
            ram_shadow[i] = 8'h00;
            dirty_shadow[i] = 1'b1;
        end
        page_shadow = '0;
        layout_shadow = 1'b0;
        scroll_x_shadow = '0;
        scroll_y_shadow = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // fresh RAM is zero and all dirty; a second fetch sees it clean
        queue_req(make_req(bstf_pkg::MODE_FETCH, 12'h000, 8'h00, 5'd0, 5'd0));
        queue_req(make_req(bstf_pkg::MODE_FETCH, 12'hfff, 8'hff, 5'd0, 5'd0));
        queue_req(make_req(bstf_pkg::MODE_FETCH, 12'h000, 8'h00, 5'd31, 5'd31));
        queue_req(make_req(bstf_pkg::MODE_READ, 12'h000, 8'h00, 5'd0, 5'd0));
        // all-ones tile: full code, colour and flip
        queue_req(make_req(bstf_pkg::MODE_WRITE, 12'h000, 8'hff, 5'd31, 5'd31));
        queue_req(make_req(bstf_pkg::MODE_WRITE, 12'h001, 8'hff, 5'd0, 5'd0));
        queue_req(make_req(bstf_pkg::MODE_READ, 12'h000, 8'h00, 5'd0, 5'd0));
        queue_req(make_req(bstf_pkg::MODE_FETCH, 12'h000, 8'h00, 5'd0, 5'd0));
        // page select ignores the upper data bits
        queue_req(make_req(bstf_pkg::MODE_PAGE, 12'hfff, 8'hff, 5'd31, 5'd31));
        queue_req(make_req(bstf_pkg::MODE_WRITE, 12'hfff, 8'h00, 5'd0, 5'd0));
        queue_req(make_req(bstf_pkg::MODE_READ, 12'hfff, 8'hff, 5'd0, 5'd0));
        queue_req(make_req(bstf_pkg::MODE_WRITE, 12'hfff, 8'ha5, 5'd0, 5'd0));
        queue_req(make_req(bstf_pkg::MODE_READ, 12'hfff, 8'h00, 5'd0, 5'd0));
        queue_req(make_req(bstf_pkg::MODE_PAGE, 12'h000, 8'hfe, 5'd0, 5'd0));
        queue_req(make_req(bstf_pkg::MODE_WRITE, 12'habc, 8'h5a, 5'd0, 5'd0));
        queue_req(make_req(bstf_pkg::MODE_READ, 12'habc, 8'h00, 5'd0, 5'd0));
        queue_req(make_req(bstf_pkg::MODE_PAGE, 12'h000, 8'h00, 5'd0, 5'd0));
        queue_req(make_req(bstf_pkg::MODE_READ, 12'hfff, 8'h00, 5'd0, 5'd0));
        // fetches at other screen positions away from the origin
        queue_req(make_req(bstf_pkg::MODE_FETCH, 12'h000, 8'h00, 5'd17, 5'd17));
        queue_req(make_req(bstf_pkg::MODE_FETCH, 12'h000, 8'h00, 5'd31, 5'd0));
        wait_drained(6);

        apply_setting(1'b1, 16'hffff, 16'hffff);
        fill_phase(PHASE_REQS);
        wait_drained(6);

        apply_setting(1'b0, 16'hffff, 16'h0000);
        fill_phase(PHASE_REQS);
        wait_drained(6);

        apply_setting(1'b1, 16'h000f, 16'h0010);
        fill_phase(PHASE_REQS);
        wait_drained(6);

        apply_setting(1'b0, 16'($urandom()), 16'($urandom()));
        fill_phase(PHASE_REQS);
        wait_drained(6);

        apply_setting(1'b1, 16'($urandom()), 16'($urandom()));
        fill_phase(PHASE_REQS);
        wait_drained(6);

        apply_setting(1'b0, 16'h0000, 16'h0000);
        fill_phase(PHASE_REQS);
        wait_drained(12);

        $display("covered %0d requests: %0d writes, %0d reads, %0d page selects, %0d fetches",
                 mode_hits[0] + mode_hits[1] + mode_hits[2] + mode_hits[3],
                 mode_hits[bstf_pkg::MODE_WRITE], mode_hits[bstf_pkg::MODE_READ],
                 mode_hits[bstf_pkg::MODE_PAGE], mode_hits[bstf_pkg::MODE_FETCH]);
        $display("%0d register writes over %0d layout/scroll settings, %0d results checked",
                 reg_writes, settings_run, results_seen);
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: allows for the clearing pass and the slowest correct run many times over
    initial
    begin
        #3000000;
        $display("timeout with %0d results still expected", expected_results.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[filelist.f]
src/bstf_pkg.sv
src/bstf_ram.sv
src/banked_scroll_tilemap_fetch_unit.sv
sim/testbench.sv
